// File: src/sst_pkg.sv
// Package for the swap slot table: shared constants, codes and beat types.
`timescale 1ns / 1ps

package sst_pkg;

  // Default sizes
  localparam int SLOTS_DEF   = 256;
  localparam int SECTORS_DEF = 8;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int SECTOR_W = 11;

  // Configuration register
  localparam int                 LIMIT_W   = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd256;
  localparam int                 PADDR_W   = 3;
  localparam int                 PDATA_W   = 32;
  localparam logic               REG_LIMIT = 1'b0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STORE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

  // Request beat
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] address;
  } sst_req_t;

  // Result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] first_sector;
  } sst_res_t;

  // Query record travelling down the cell chain
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] address;
    logic             hit;
    logic             free;
  } sst_rec_t;

  // Broadcast write to one cell
  typedef struct packed {
    logic             valid;
    logic             claim;
    logic [KEY_W-1:0] key;
  } sst_upd_t;

endpackage

// File: src/sst_cell.sv
// One slot cell: used bit and key, plus one stage of the query chain.
`timescale 1ns / 1ps

module sst_cell #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF,
  parameter int INDEX = 0,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sst_pkg::LIMIT_W-1:0] limit,
  input  sst_pkg::sst_rec_t           rec_in,
  input  logic [IDX_W-1:0]            hit_idx_in,
  input  logic [IDX_W-1:0]            free_idx_in,
  output sst_pkg::sst_rec_t           rec_out,
  output logic [IDX_W-1:0]            hit_idx_out,
  output logic [IDX_W-1:0]            free_idx_out,
  input  sst_pkg::sst_upd_t           upd,
  input  logic [IDX_W-1:0]            upd_idx
);
  import sst_pkg::*;

  localparam int               CMP_W   = ((IDX_W > LIMIT_W) ? IDX_W : LIMIT_W) + 1;
  localparam logic [IDX_W-1:0] OWN_IDX = IDX_W'(INDEX);
  localparam logic [CMP_W-1:0] OWN_CMP = CMP_W'(INDEX);

  logic             used;
  logic [KEY_W-1:0] key;
  logic             match;
  logic             cand;
  logic             upd_here;
  sst_rec_t         rec_next;

  // Slot state compare
  assign match    = used && (key == rec_in.address);
  assign cand     = !used && (OWN_CMP < CMP_W'(limit));
  assign upd_here = upd.valid && (upd_idx == OWN_IDX);

  // First match and first free slot win
  always_comb begin
    rec_next      = rec_in;
    rec_next.hit  = rec_in.hit | match;
    rec_next.free = rec_in.free | cand;
  end

  // Chain stage
  always_ff @(posedge clk) begin
    rec_out.cmd     <= rec_next.cmd;
    rec_out.address <= rec_next.address;
    rec_out.hit     <= rec_next.hit;
    rec_out.free    <= rec_next.free;
    hit_idx_out     <= rec_in.hit ? hit_idx_in : OWN_IDX;
    free_idx_out    <= rec_in.free ? free_idx_in : OWN_IDX;
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else begin
      rec_out.valid <= rec_next.valid;
    end
  end

  // Used bit, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (upd_here) begin
      used <= upd.claim;
    end
  end

  // Key, written on claim
  always_ff @(posedge clk) begin
    if (upd_here && upd.claim) begin
      key <= upd.key;
    end
  end

endmodule

// File: src/swap_slot_table_unit.sv
// Swap slot table top level: command port, limit register and the cell chain.
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  request   | start, busy, request                 | in
//  result    | done, result                         | out
//  config    | psel penable pwrite paddr pwdata ... | in/out
//
// A command passes the head register, then walks the row of SLOTS cells one per
// cycle; the decision at the end of the row then writes the result register and
// the done beat. busy is high from accept until the done beat is shown, and the
// next command may start in the cycle the done beat is shown.
// Reset clears all used bits and sets slot_limit to 256; no clearing pass.
// The result beat cannot be stalled.
`timescale 1ns / 1ps

module swap_slot_table_unit #(
  parameter int SLOTS            = sst_pkg::SLOTS_DEF,
  parameter int SECTORS_PER_SLOT = sst_pkg::SECTORS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  sst_pkg::sst_req_t           request,
  output logic                        done,
  output sst_pkg::sst_res_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sst_pkg::PADDR_W-1:0] paddr,
  input  logic [sst_pkg::PDATA_W-1:0] pwdata,
  output logic [sst_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sst_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [LIMIT_W-1:0] slot_limit;
  logic               cfg_wr;

  sst_rec_t           head;
  sst_rec_t           rec      [SLOTS+1];
  logic [IDX_W-1:0]   hit_idx  [SLOTS+1];
  logic [IDX_W-1:0]   free_idx [SLOTS+1];
  sst_rec_t           tail;

  sst_upd_t           upd;
  logic [IDX_W-1:0]   upd_idx;
  sst_upd_t           upd_next;
  logic [IDX_W-1:0]   upd_idx_next;
  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]   res_idx_next;
  logic               res_some;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(slot_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= LIMIT_RST;
    end else if (cfg_wr && (paddr[2] == REG_LIMIT)) begin
      slot_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Query injection at the head of the chain
  always_ff @(posedge clk) begin
    head.cmd     <= request.command;
    head.address <= request.address;
    head.hit     <= 1'b0;
    head.free    <= 1'b0;
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= start && !busy;
    end
  end

  assign rec[0]      = head;
  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  // Row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sst_cell #(
      .SLOTS (SLOTS),
      .INDEX (g)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .limit        (slot_limit),
      .rec_in       (rec[g]),
      .hit_idx_in   (hit_idx[g]),
      .free_idx_in  (free_idx[g]),
      .rec_out      (rec[g+1]),
      .hit_idx_out  (hit_idx[g+1]),
      .free_idx_out (free_idx[g+1]),
      .upd          (upd),
      .upd_idx      (upd_idx)
    );
  end

  assign tail = rec[SLOTS];

  // Decision at the end of the chain
  always_comb begin
    upd_next       = '0;
    upd_next.key   = tail.address;
    upd_idx_next   = hit_idx[SLOTS];
    status_next    = ST_OK;
    res_idx_next   = '0;
    res_some       = 1'b0;
    case (tail.cmd) inside
      CMD_STORE: begin
        if (tail.hit) begin
          status_next = ST_DUPLICATE;
        end else if (tail.free) begin
          upd_next.valid = tail.valid;
          upd_next.claim = 1'b1;
          upd_idx_next   = free_idx[SLOTS];
          res_idx_next   = free_idx[SLOTS];
          res_some       = 1'b1;
        end else begin
          status_next = ST_FULL;
        end
      end
      CMD_FETCH, CMD_RELEASE: begin
        if (tail.hit) begin
          upd_next.valid = tail.valid;
          res_idx_next   = hit_idx[SLOTS];
          res_some       = 1'b1;
        end else begin
          status_next = ST_MISSING;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Slot write back, registered in the cycle after the decision
  always_ff @(posedge clk) begin
    upd.claim <= upd_next.claim;
    upd.key   <= upd_next.key;
    upd_idx   <= upd_idx_next;
    if (rst) begin
      upd.valid <= 1'b0;
    end else begin
      upd.valid <= upd_next.valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      result.status       <= status_next;
      result.slot         <= res_some ? SLOT_W'(res_idx_next) : '0;
      result.first_sector <= res_some ? SECTOR_W'(res_idx_next * SECTORS_PER_SLOT) : '0;
    end
  end

  // Handshake control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tail.valid;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: tb/tb_swap_slot_table_unit.sv
// Testbench for the swap slot table: directed and random beats checked against a slot-map predictor.
`timescale 1ns / 1ps

module tb_swap_slot_table_unit;
  import sst_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int SPS          = SECTORS_DEF;
  localparam int CMD_LATENCY  = SLOTS + 2;
  localparam int SETTLE_LIMIT = 8 * CMD_LATENCY;
  localparam int CYCLE_LIMIT  = 1_500_000;

  // Command code the block must ignore
  localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR    = {REG_LIMIT, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  // Mirror of the slot map plus the outcomes still owed by the block
  class slot_table_scoreboard;
    bit               used[SLOTS];
    bit [KEY_W-1:0]   key[SLOTS];
    int unsigned      limit;
    sst_res_t         outcomes_due[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      per_status[4];

    function new();
      foreach (used[i]) used[i] = 1'b0;
      foreach (per_status[i]) per_status[i] = 0;
      limit   = LIMIT_RST;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int find_key(logic [KEY_W-1:0] addr);
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i] && key[i] == addr) return i;
      end
      return -1;
    endfunction

    // Apply one command to the map and work out the beat it must produce
    function sst_res_t claim_or_lookup(sst_req_t req);
      sst_res_t res;
      int       hit;
      int       cap;
      res = '0;
      hit = find_key(req.address);
      cap = (limit > SLOTS) ? SLOTS : limit;
      case (req.command)
        CMD_STORE: begin
          if (hit >= 0) begin
            res.status = ST_DUPLICATE;
          end else begin
            res.status = ST_FULL;
            for (int i = 0; i < cap && res.status == ST_FULL; i++) begin
              if (!used[i]) begin
                used[i]          = 1'b1;
                key[i]           = req.address;
                res.status       = ST_OK;
                res.slot         = SLOT_W'(i);
                res.first_sector = SECTOR_W'(i * SPS);
              end
            end
          end
        end
        CMD_FETCH, CMD_RELEASE: begin
          if (hit < 0) begin
            res.status = ST_MISSING;
          end else begin
            used[hit]        = 1'b0;
            res.status       = ST_OK;
            res.slot         = SLOT_W'(hit);
            res.first_sector = SECTOR_W'(hit * SPS);
          end
        end
        default: res.status = ST_OK;  // unused code: no effect, zero beat
      endcase
      return res;
    endfunction

    function void note_command(sst_req_t req);
      outcomes_due.push_back(claim_or_lookup(req));
    endfunction

    function void check_outcome(sst_res_t got);
      sst_res_t want;
      if (outcomes_due.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d slot %0d sector %0d",
               got.status, got.slot, got.first_sector);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      checked++;
      per_status[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.first_sector !== want.first_sector) begin
        $error("first_sector: expected %0d, got %0d", want.first_sector, got.first_sector);
        errors++;
      end
    endfunction

    function void flush_missing();
      sst_res_t want;
      while (outcomes_due.size() > 0) begin
        want = outcomes_due.pop_front();
        $error("result beat never came: status %0d slot %0d sector %0d",
               want.status, want.slot, want.first_sector);
        errors++;
      end
    endfunction

    // Key of some used slot, chosen from a random starting point
    function bit pick_held(output bit [KEY_W-1:0] addr);
      int base;
      base = $urandom_range(0, SLOTS - 1);
      addr = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (used[(base + i) % SLOTS]) begin
          addr = key[(base + i) % SLOTS];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  logic               busy;
  sst_req_t           request = '0;
  logic               done;
  sst_res_t           result;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  slot_table_scoreboard sb;
  bit                   idle_gaps;
  int unsigned          limit_settings;

  swap_slot_table_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Accepted command beats and result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_command(request);
      if (done) sb.check_outcome(result);
    end
  end

  // One command beat; start stays high so a zero gap runs back to back
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] addr);
    int unsigned gap;
    gap = idle_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= '{command: cmd, address: addr};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // APB setup and access; rdata is taken at the access edge
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_limit();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, LIMIT_ADDR, '0, rd);
    if (rd !== PDATA_W'(sb.limit)) begin
      $error("slot_limit readback: expected %0d, got %0d", sb.limit, rd);
      sb.errors++;
    end
  endtask

  // Upper data bits are junk; only the low 9 bits land in the register
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, LIMIT_ADDR, ($urandom() & ~32'h1FF) | PDATA_W'(value), rd);
    sb.set_limit(value);
    limit_settings++;
    check_limit();
  endtask

  // Drop start, wait out the outstanding beats, then flag any that never came
  task automatic settle();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (sb.outcomes_due.size() > 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (CMD_LATENCY + 2) @(posedge clk);
    sb.flush_missing();
  endtask

  // One of eight keys next to zero or all ones, so lookups and stores collide
  function automatic logic [KEY_W-1:0] near_edge_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom_range(0, 3));
    return ($urandom_range(0, 1) != 0) ? k : ~k;
  endfunction

  // Random traffic: mostly stores of new keys and lookups of held keys
  task automatic run_phase(input int unsigned items, input int unsigned store_pct);
    logic [KEY_W-1:0] addr;
    bit [KEY_W-1:0]   held;
    int unsigned      pick;
    int unsigned      pick2;
    idle_gaps = ($urandom_range(0, 3) != 0);
    repeat (items) begin
      pick  = $urandom_range(0, 99);
      pick2 = $urandom_range(0, 99);
      if (pick < store_pct) begin
        if (pick2 < 10 && sb.pick_held(held)) addr = held;
        else if (pick2 < 20) addr = near_edge_key();
        else addr = $urandom;
        send_cmd(CMD_STORE, addr);
      end else if (pick < 97) begin
        if (pick2 < 80 && sb.pick_held(held)) addr = held;
        else if (pick2 < 90) addr = near_edge_key();
        else addr = $urandom;
        send_cmd(($urandom_range(0, 1) != 0) ? CMD_FETCH : CMD_RELEASE, addr);
      end else begin
        send_cmd(CMD_UNUSED, $urandom);
      end
    end
    settle();
  endtask

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [PDATA_W-1:0] junk;
    sb             = new();
    limit_settings = 1;
    idle_gaps      = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value, then a write past the register list must change nothing
    check_limit();
    apb_access(1'b1, UNMAPPED_ADDR, $urandom, junk);
    check_limit();

    // Directed: key extremes, duplicates, misses, unused code
    send_cmd(CMD_STORE, 32'h0000_0000);
    send_cmd(CMD_STORE, 32'hFFFF_FFFF);
    send_cmd(CMD_STORE, 32'hFFFF_FFFF);
    send_cmd(CMD_FETCH, 32'h0000_0000);
    send_cmd(CMD_FETCH, 32'h0000_0000);
    send_cmd(CMD_STORE, 32'h5A5A_5A5A);
    send_cmd(CMD_RELEASE, 32'hFFFF_FFFF);
    send_cmd(CMD_RELEASE, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED, 32'hA5A5_A5A5);
    settle();

    // Tiny table: full, and duplicate while full
    write_limit(9'd2);
    send_cmd(CMD_STORE, 32'h0000_0001);
    send_cmd(CMD_STORE, 32'h0000_0002);
    send_cmd(CMD_STORE, 32'h0000_0001);
    settle();

    // Slot held above a lowered limit is still found
    write_limit(9'd1);
    send_cmd(CMD_FETCH, 32'h0000_0001);
    send_cmd(CMD_STORE, 32'h0000_0003);
    settle();

    // Zero limit refuses every store
    write_limit(9'd0);
    send_cmd(CMD_STORE, 32'h0000_0004);
    send_cmd(CMD_RELEASE, 32'h5A5A_5A5A);
    send_cmd(CMD_STORE, 32'h0000_0004);
    settle();

    // Limit beyond the table size acts as the table size
    write_limit(9'h1FF);
    send_cmd(CMD_STORE, 32'h0000_0007);
    send_cmd(CMD_FETCH, 32'h0000_0007);
    settle();

    // Random phases; the first one fills the whole table
    write_limit(9'd256);
    run_phase(360, 95);
    write_limit(9'd3);
    run_phase(80, 40);
    write_limit(9'd0);
    run_phase(30, 60);
    write_limit(9'd1);
    run_phase(40, 50);
    write_limit(LIMIT_W'($urandom_range(1, 256)));
    run_phase(100, 50);
    write_limit(LIMIT_W'($urandom_range(257, 511)));
    run_phase(90, 55);
    write_limit(9'd256);
    run_phase(100, 50);

    $display("Checked %0d result beats: %0d ok, %0d full, %0d not found, %0d duplicate",
             sb.checked, sb.per_status[ST_OK], sb.per_status[ST_FULL],
             sb.per_status[ST_MISSING], sb.per_status[ST_DUPLICATE]);
    $display("Went through %0d slot_limit settings, from zero up to the 9-bit maximum",
             limit_settings);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
